[rtl/core/mwcs_pkg.sv]
package mwcs_pkg;

  localparam int K_MAX   = 128;
  localparam int MAX_LEN = 4096;

  localparam int VALUE_W = 16;
  localparam int TC_W    = 8;
  localparam int K_W     = $clog2(K_MAX + 1);
  localparam int KIDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int HADDR_W = $clog2(MAX_LEN);

  localparam int PADDR_W = 3;
  localparam logic ADDR_TARGET_COUNT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_CHECK,
    S_POP_H,
    S_POP_C,
    S_DONE
  } state_t;

  function automatic logic [K_W-1:0] effective_k(input logic [TC_W-1:0] tc);
    logic [K_W-1:0] k;
    if (tc == '0) begin
      k = K_W'(1);
    end else if (32'(tc) > 32'(K_MAX)) begin
      k = K_W'(K_MAX);
    end else begin
      k = K_W'(tc);
    end
    return k;
  endfunction

  function automatic logic in_range(input logic [VALUE_W-1:0] v, input logic [K_W-1:0] k);
    return (v != '0) && (32'(v) <= 32'(k));
  endfunction

endpackage

[rtl/core/min_window_covering_set.sv]
// Finds the shortest run of the request sequence that holds every value from 1 to k.
// A request whose value lies in 1..k increments its count; while the window holds every
// value, older requests leave it and those in 1..k decrement their count. The last
// request yields the result, which waits while the previous result is still stalled.
// A new request is taken only once the previous one is through. A dropped request is
// not stored. The history and count memories each have a single read port.
// Values above k and zero only add to window length. Requests past 4096 are dropped
// and flagged. k is taken from target_count at the first request of a sequence.
module min_window_covering_set (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mwcs_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mwcs_pkg::VALUE_W-1:0]      value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic [12:0]                       min_length,
  output logic                              overflow
);

  mwcs_pkg::state_t state, state_next;

  logic [mwcs_pkg::TC_W-1:0]    target_count;
  logic [mwcs_pkg::K_W-1:0]     k_used;
  logic                         seq_active;
  logic                         last_r;
  logic [mwcs_pkg::K_W-1:0]     distinct;
  logic [mwcs_pkg::LEN_W-1:0]   wstart;
  logic [mwcs_pkg::LEN_W-1:0]   wend;
  logic [mwcs_pkg::HADDR_W-1:0] hi;
  logic [mwcs_pkg::LEN_W-1:0]   best;
  logic                         found_flag;
  logic                         overflow_flag;
  logic [mwcs_pkg::KIDX_W-1:0]  idx;
  logic [mwcs_pkg::K_MAX-1:0]   cnt_valid;

  logic                         cnt_we;
  logic [mwcs_pkg::KIDX_W-1:0]  cnt_raddr;
  logic [mwcs_pkg::LEN_W-1:0]   cnt_wdata;
  logic [mwcs_pkg::LEN_W-1:0]   cnt_rdata;
  logic [mwcs_pkg::LEN_W-1:0]   cnt_cur;
  logic                         hist_we;
  logic [mwcs_pkg::HADDR_W-1:0] hist_raddr;
  logic [mwcs_pkg::VALUE_W-1:0] hist_rdata;

  logic                         accept;
  logic                         cfg_write;
  logic [mwcs_pkg::K_W-1:0]     k_cur;
  logic                         is_full;
  logic                         covered;
  logic                         old_in;
  logic                         emit;
  logic [mwcs_pkg::LEN_W-1:0]   len;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == mwcs_pkg::ADDR_TARGET_COUNT);
  assign prdata    = (paddr[2] == mwcs_pkg::ADDR_TARGET_COUNT) ? 32'(target_count) : '0;

  assign in_stall  = (state != mwcs_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign k_cur     = seq_active ? k_used : mwcs_pkg::effective_k(target_count);
  assign is_full   = (32'(wend) >= 32'(mwcs_pkg::MAX_LEN));
  assign covered   = (wstart <= mwcs_pkg::LEN_W'(hi)) && (distinct == k_used);
  assign old_in    = mwcs_pkg::in_range(hist_rdata, k_used);
  assign cnt_cur   = cnt_valid[idx] ? cnt_rdata : '0;
  assign emit      = !out_valid || !out_stall;
  assign len       = mwcs_pkg::LEN_W'(hi) - wstart + mwcs_pkg::LEN_W'(1);

  mwcs_ram #(
    .WIDTH (mwcs_pkg::LEN_W),
    .DEPTH (mwcs_pkg::K_MAX)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mwcs_ram #(
    .WIDTH (mwcs_pkg::VALUE_W),
    .DEPTH (mwcs_pkg::MAX_LEN)
  ) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wend[mwcs_pkg::HADDR_W-1:0]),
    .wdata (value),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      mwcs_pkg::S_IDLE: begin
        if (accept) begin
          if (is_full) begin
            state_next = last ? mwcs_pkg::S_DONE : mwcs_pkg::S_IDLE;
          end else if (mwcs_pkg::in_range(value, k_cur)) begin
            state_next = mwcs_pkg::S_INC;
          end else begin
            state_next = mwcs_pkg::S_CHECK;
          end
        end
      end
      mwcs_pkg::S_INC: begin
        state_next = mwcs_pkg::S_CHECK;
      end
      mwcs_pkg::S_CHECK: begin
        if (covered) begin
          state_next = mwcs_pkg::S_POP_H;
        end else begin
          state_next = last_r ? mwcs_pkg::S_DONE : mwcs_pkg::S_IDLE;
        end
      end
      mwcs_pkg::S_POP_H: begin
        state_next = old_in ? mwcs_pkg::S_POP_C : mwcs_pkg::S_CHECK;
      end
      mwcs_pkg::S_POP_C: begin
        state_next = mwcs_pkg::S_CHECK;
      end
      mwcs_pkg::S_DONE: begin
        if (emit) begin
          state_next = mwcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mwcs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_cur;
    cnt_raddr  = idx;
    hist_we    = 1'b0;
    hist_raddr = wstart[mwcs_pkg::HADDR_W-1:0];
    case (state)
      mwcs_pkg::S_IDLE: begin
        hist_we   = accept && !is_full;
        cnt_raddr = mwcs_pkg::KIDX_W'(value - mwcs_pkg::VALUE_W'(1));
      end
      mwcs_pkg::S_INC: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_cur + mwcs_pkg::LEN_W'(1);
      end
      mwcs_pkg::S_POP_H: begin
        cnt_raddr = mwcs_pkg::KIDX_W'(hist_rdata - mwcs_pkg::VALUE_W'(1));
      end
      mwcs_pkg::S_POP_C: begin
        cnt_we    = (cnt_cur != '0);
        cnt_wdata = cnt_cur - mwcs_pkg::LEN_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mwcs_pkg::S_IDLE;
      target_count  <= mwcs_pkg::TC_W'(1);
      k_used        <= mwcs_pkg::K_W'(1);
      seq_active    <= 1'b0;
      distinct      <= '0;
      wstart        <= '0;
      wend          <= '0;
      best          <= mwcs_pkg::LEN_W'(mwcs_pkg::MAX_LEN);
      found_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      cnt_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        target_count <= pwdata[mwcs_pkg::TC_W-1:0];
      end
      if ((state == mwcs_pkg::S_DONE) && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        mwcs_pkg::S_IDLE: begin
          if (accept) begin
            k_used     <= k_cur;
            seq_active <= 1'b1;
            if (is_full) begin
              overflow_flag <= 1'b1;
            end else begin
              hi   <= wend[mwcs_pkg::HADDR_W-1:0];
              wend <= wend + mwcs_pkg::LEN_W'(1);
            end
          end
        end
        mwcs_pkg::S_INC: begin
          cnt_valid[idx] <= 1'b1;
          if (cnt_cur == '0) begin
            distinct <= distinct + mwcs_pkg::K_W'(1);
          end
        end
        mwcs_pkg::S_CHECK: begin
          if (covered) begin
            found_flag <= 1'b1;
            if (len < best) begin
              best <= len;
            end
          end
        end
        mwcs_pkg::S_POP_H: begin
          if (!old_in) begin
            wstart <= wstart + mwcs_pkg::LEN_W'(1);
          end
        end
        mwcs_pkg::S_POP_C: begin
          wstart <= wstart + mwcs_pkg::LEN_W'(1);
          if (cnt_cur == mwcs_pkg::LEN_W'(1)) begin
            distinct <= distinct - mwcs_pkg::K_W'(1);
          end
        end
        mwcs_pkg::S_DONE: begin
          if (emit) begin
            seq_active    <= 1'b0;
            distinct      <= '0;
            wstart        <= '0;
            wend          <= '0;
            best          <= mwcs_pkg::LEN_W'(mwcs_pkg::MAX_LEN);
            found_flag    <= 1'b0;
            overflow_flag <= 1'b0;
            cnt_valid     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last;
    end
    case (state)
      mwcs_pkg::S_IDLE: begin
        idx <= mwcs_pkg::KIDX_W'(value - mwcs_pkg::VALUE_W'(1));
      end
      mwcs_pkg::S_POP_H: begin
        idx <= mwcs_pkg::KIDX_W'(hist_rdata - mwcs_pkg::VALUE_W'(1));
      end
      default: begin
      end
    endcase
    if ((state == mwcs_pkg::S_DONE) && emit) begin
      found      <= found_flag;
      min_length <= found_flag ? 13'(best) : '0;
      overflow   <= overflow_flag;
    end
  end

endmodule

[rtl/core/mwcs_ram.sv]
module mwcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
